[hw/rtl/hftq_pkg.sv]
// shared types and constants for the terrain height query block
`timescale 1ns / 1ps
package hftq_pkg;

	// table geometry and field widths
	localparam int ADDR_W = 16;
	localparam int H_W    = 16;
	localparam int CFG_W  = 24;
	localparam int CIDX_W = 3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_ORIGIN_Z     = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_TERRAIN_SIZE = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_GRID_POINTS  = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_MAX_HEIGHT   = 3'd4;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hw/rtl/hftq_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hftq_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output hftq_pkg::div_stat_t  stat,
	output logic [NUM_W-1:0]     quot
);
	import hftq_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] den_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, sh_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = sh_q;

endmodule

[hw/rtl/hftq_mem.sv]
// height table memory, one write and one registered read port
`timescale 1ns / 1ps
module hftq_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [hftq_pkg::ADDR_W-1:0]  waddr,
	input  logic [hftq_pkg::H_W-1:0]     wdata,
	input  logic [hftq_pkg::ADDR_W-1:0]  raddr,
	output logic [hftq_pkg::H_W-1:0]     rdata
);
	import hftq_pkg::*;

	logic [H_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/heightfield_triangle_height_query_top.sv]
// top level: configuration, query sequencer and load path
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | kind grid_index sample world_x world_z
//  out     | output    | out_valid/out_stall | height inside_res
//  cfg     | input     | cfg_we              | cfg_index cfg_data
//
// a load beat is captured, then written to the table; a query beat runs subtract,
// multiply, a bit-serial divide of QW = 24 + clog2(GRID_MAX) + FRAC_BITS bits, the
// inside check and three serial corner reads, the reads skipped outside the grid
// reset clears control and configuration only, the table holds garbage until loaded
// a finished result waits in the output register while the next beat is taken
`timescale 1ns / 1ps
module heightfield_triangle_height_query_top #(
	parameter int GRID_MAX  = 256,
	parameter int FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [15:0]                   grid_index,
	input  logic [15:0]                   sample,
	input  logic signed [23:0]            world_x,
	input  logic signed [23:0]            world_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            height,
	output logic                          inside_res,
	input  logic                          cfg_we,
	input  logic [hftq_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [hftq_pkg::CFG_W-1:0]    cfg_data
);
	import hftq_pkg::*;

	localparam int CW  = (GRID_MAX > 2) ? $clog2(GRID_MAX) : 1;
	localparam int NB  = $clog2(GRID_MAX + 1);
	localparam int PW  = 24 + CW;
	localparam int QW  = PW + FRAC_BITS;
	localparam int WW  = FRAC_BITS + 1;
	localparam int PRW = H_W + WW + 1;
	localparam int AW  = PRW + 2;
	localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOAD = 10'b0000000010,
		S_SUB  = 10'b0000000100,
		S_MUL  = 10'b0000001000,
		S_DST  = 10'b0000010000,
		S_DIV  = 10'b0000100000,
		S_CHK  = 10'b0001000000,
		S_ADR  = 10'b0010000000,
		S_RD   = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [23:0] origin_x_q, origin_z_q;
	logic [22:0]        terrain_size_q;
	logic [8:0]         grid_points_q;
	logic [13:0]        max_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_z_q     <= '0;
			terrain_size_q <= 23'd204800;
			grid_points_q  <= 9'd256;
			max_height_q   <= 14'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:     origin_x_q     <= cfg_data;
				CFG_ORIGIN_Z:     origin_z_q     <= cfg_data;
				CFG_TERRAIN_SIZE: terrain_size_q <= cfg_data[22:0];
				CFG_GRID_POINTS:  grid_points_q  <= cfg_data[8:0];
				CFG_MAX_HEIGHT:   max_height_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// effective grid size, cell count and terrain size
	logic [31:0]   n_int;
	logic [NB-1:0] n_c;
	logic [CW-1:0] cells;
	logic [22:0]   size_c;

	always_comb begin
		if (grid_points_q < 9'd2) begin
			n_int = 32'd2;
		end else if (32'(grid_points_q) > 32'(GRID_MAX)) begin
			n_int = 32'(GRID_MAX);
		end else begin
			n_int = 32'(grid_points_q);
		end
		n_c    = NB'(n_int);
		cells  = CW'(n_int - 32'd1);
		size_c = (terrain_size_q == '0) ? 23'd1 : terrain_size_q;
	end

	// captured beat
	logic [15:0]        idx_q, smp_q;
	logic signed [23:0] wx_q, wz_q;

	// load conversion
	logic [29:0]        lprod;
	logic [30:0]        lrnd;
	logic signed [16:0] lval;
	logic [H_W-1:0]     lsat;

	always_comb begin
		lprod = 30'(smp_q) * 30'(max_height_q);
		lrnd  = 31'(lprod) + 31'd16384;
		lval  = $signed({1'b0, lrnd[30:15]}) - 17'sd256;
		if (lval > 17'sd32767) begin
			lsat = 16'h7fff;
		end else if (lval < -17'sd32768) begin
			lsat = 16'h8000;
		end else begin
			lsat = lval[15:0];
		end
	end

	// offsets from the origin
	logic signed [24:0] tx_q, tz_q;
	logic [PW-1:0]      px_q, pz_q;

	// dividers
	div_stat_t       dx_stat, dz_stat;
	logic [QW-1:0]   qx, qz;
	logic            div_start;

	assign div_start = (state_q == S_DST);

	hftq_div #(.NUM_W(QW), .DEN_W(23)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({px_q, FRAC_BITS'(0)}),
		.den    (size_c),
		.stat   (dx_stat),
		.quot   (qx)
	);

	hftq_div #(.NUM_W(QW), .DEN_W(23)) u_div_z (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({pz_q, FRAC_BITS'(0)}),
		.den    (size_c),
		.stat   (dz_stat),
		.quot   (qz)
	);

	// cell, fraction and inside test
	logic [PW-1:0]        cx, cz;
	logic [FRAC_BITS-1:0] fx, fz;
	logic                 in_grid;

	always_comb begin
		cx      = qx[QW-1:FRAC_BITS];
		cz      = qz[QW-1:FRAC_BITS];
		fx      = qx[FRAC_BITS-1:0];
		fz      = qz[FRAC_BITS-1:0];
		in_grid = !tx_q[24] && !tz_q[24] && (cx < PW'(cells)) && (cz < PW'(cells));
	end

	logic [FRAC_BITS-1:0] fx_q, fz_q;
	logic [ADDR_W-1:0]    base_q;
	logic                 inside_q;

	// triangle selection and corner weights
	logic [WW:0]       fsum;
	logic              upper;
	logic [ADDR_W-1:0] a_base1, a_basen, a_basen1;
	logic [WW:0]       w0, w1, w2;

	always_comb begin
		fsum     = (WW+1)'(fx_q) + (WW+1)'(fz_q);
		upper    = fsum > (WW+1)'(ONE);
		a_base1  = base_q + ADDR_W'(1);
		a_basen  = base_q + ADDR_W'(n_c);
		a_basen1 = a_basen + ADDR_W'(1);
		if (upper) begin
			w0 = (WW+1)'(ONE) - (WW+1)'(fz_q);
			w1 = fsum - (WW+1)'(ONE);
			w2 = (WW+1)'(ONE) - (WW+1)'(fx_q);
		end else begin
			w0 = (WW+1)'(ONE) - fsum;
			w1 = (WW+1)'(fx_q);
			w2 = (WW+1)'(fz_q);
		end
	end

	logic [ADDR_W-1:0] addr_q [3];
	logic [WW-1:0]     wgt_q [3];
	logic [2:0]        step_q;

	// table
	logic [H_W-1:0]    rdata;
	logic [ADDR_W-1:0] raddr;

	always_comb begin
		unique case (step_q)
			3'd0:    raddr = addr_q[0];
			3'd1:    raddr = addr_q[1];
			default: raddr = addr_q[2];
		endcase
	end

	hftq_mem u_mem (
		.clk   (clk),
		.we    (state_q == S_LOAD),
		.waddr (idx_q),
		.wdata (lsat),
		.raddr (raddr),
		.rdata (rdata)
	);

	// multiply and accumulate of the corner heights
	logic [WW-1:0]        wsel;
	logic signed [PRW-1:0] prod_q;
	logic signed [AW-1:0]  acc_q;

	always_comb begin
		unique case (step_q)
			3'd1:    wsel = wgt_q[0];
			3'd2:    wsel = wgt_q[1];
			default: wsel = wgt_q[2];
		endcase
	end

	// rounding and saturation
	logic signed [AW-1:0] rnd;
	logic signed [AW-1:0] hsh;
	logic [H_W-1:0]       hsat;

	always_comb begin
		rnd = acc_q + AW'(ONE >> 1);
		hsh = rnd >>> FRAC_BITS;
		if (hsh > AW'(32767)) begin
			hsat = 16'h7fff;
		end else if (hsh < -AW'(32768)) begin
			hsat = 16'h8000;
		end else begin
			hsat = hsh[15:0];
		end
	end

	// sequencer control
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			// result register: fill from the done state, empty on an accepted beat
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (kind == KIND_LOAD) ? S_LOAD : S_SUB;
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_SUB:  state_q <= S_MUL;
				S_MUL:  state_q <= S_DST;
				S_DST:  state_q <= S_DIV;
				S_DIV: begin
					if (dx_stat.done && dz_stat.done && !dx_stat.busy && !dz_stat.busy) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= in_grid ? S_ADR : S_DONE;
				S_ADR: begin
					state_q <= S_RD;
					step_q  <= '0;
				end
				S_RD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					idx_q <= grid_index;
					smp_q <= sample;
					wx_q  <= world_x;
					wz_q  <= world_z;
				end
			end
			S_SUB: begin
				tx_q <= 25'(wx_q) - 25'(origin_x_q);
				tz_q <= 25'(wz_q) - 25'(origin_z_q);
			end
			S_MUL: begin
				px_q <= PW'(tx_q[23:0]) * PW'(cells);
				pz_q <= PW'(tz_q[23:0]) * PW'(cells);
			end
			S_CHK: begin
				fx_q     <= fx;
				fz_q     <= fz;
				inside_q <= in_grid;
				base_q   <= ADDR_W'(cx[CW-1:0]) + ADDR_W'(ADDR_W'(cz[CW-1:0]) * ADDR_W'(n_c));
				acc_q    <= '0;
			end
			S_ADR: begin
				addr_q[0] <= upper ? a_base1 : base_q;
				addr_q[1] <= upper ? a_basen1 : a_base1;
				addr_q[2] <= a_basen;
				wgt_q[0]  <= w0[WW-1:0];
				wgt_q[1]  <= w1[WW-1:0];
				wgt_q[2]  <= w2[WW-1:0];
			end
			S_RD: begin
				if (step_q >= 3'd1 && step_q <= 3'd3) begin
					prod_q <= PRW'($signed(rdata)) * $signed({1'b0, wsel});
				end
				if (step_q >= 3'd2) begin
					acc_q <= acc_q + AW'(prod_q);
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					height     <= inside_q ? hsat : '0;
					inside_res <= inside_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[bench/heightfield_triangle_height_query_top_tb.sv]
// testbench for the terrain height query block: loads, queries and register settings
`timescale 1ns / 1ps
module heightfield_triangle_height_query_top_tb;
	import hftq_pkg::*;

	localparam int FRAC   = 8;
	localparam int GMAX   = 256;
	localparam int LIMIT  = 3000000;
	localparam int ITEMS  = 1550;
	localparam int SETTLE = 80;

	typedef struct {
		logic signed [15:0] h;
		logic               ins;
	} height_res_t;

	typedef struct {
		logic               k;
		logic [15:0]        idx;
		logic [15:0]        smp;
		logic signed [23:0] wx;
		logic signed [23:0] wz;
		bit                 typed;
		logic signed [15:0] h;
		logic               ins;
	} stim_row_t;

	typedef struct {
		logic signed [23:0] ox;
		logic signed [23:0] oz;
		logic [23:0]        size;
		logic [23:0]        gp;
		logic [23:0]        mh;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_LOAD;
	logic [15:0] grid_index = '0;
	logic [15:0] sample = '0;
	logic signed [23:0] world_x = '0;
	logic signed [23:0] world_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] height;
	logic inside_res;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = CFG_ORIGIN_X;
	logic [CFG_W-1:0] cfg_data = '0;

	heightfield_triangle_height_query_top dut (.*);

	always #5 clk = ~clk;

	// shadow of the block's registers and height table
	logic signed [23:0] m_ox = 0, m_oz = 0;
	logic [22:0] m_size = 23'd204800;
	logic [8:0] m_gp = 9'd256;
	logic [13:0] m_mh = 14'd256;
	logic signed [15:0] heights [65536];
	bit loaded [65536];

	height_res_t pending_heights [$];
	int errors = 0;
	int items_sent = 0;
	int cycles = 0;
	int long_hold = 0;
	int out_wait = 0;
	bit calm = 1'b0;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic logic signed [15:0] load_height(logic [15:0] s);
		longint prod;
		prod = longint'(s) * longint'(m_mh);
		return clamp16(((prod + 16384) >>> 15) - 256);
	endfunction

	// cell and fraction along one axis
	function automatic bit axis_pos(longint t, longint cells, longint size,
		output longint cpos, output longint frac);
		longint p;
		cpos = 0;
		frac = 0;
		if (t < 0) return 1'b0;
		p = t * cells;
		if (p / size >= cells) return 1'b0;
		cpos = p / size;
		frac = ((p % size) <<< FRAC) / size;
		return 1'b1;
	endfunction

	// grid position of a query: base address, row pitch and fractions
	function automatic bit grid_pos(logic signed [23:0] wx, logic signed [23:0] wz,
		output longint base, output longint n, output longint fx, output longint fz);
		longint size, gx, gz;
		n = m_gp < 2 ? 2 : (m_gp > GMAX ? GMAX : m_gp);
		size = m_size == 0 ? 1 : m_size;
		base = 0;
		fz = 0;
		gz = 0;
		if (!axis_pos(longint'(wx) - longint'(m_ox), n - 1, size, gx, fx)) return 1'b0;
		if (!axis_pos(longint'(wz) - longint'(m_oz), n - 1, size, gz, fz)) return 1'b0;
		base = gx + gz * n;
		return 1'b1;
	endfunction

	function automatic longint corner(longint a);
		return longint'(heights[a[15:0]]);
	endfunction

	function automatic height_res_t query_height(logic signed [23:0] wx,
		logic signed [23:0] wz);
		height_res_t r;
		longint base, n, fx, fz, sum;
		longint one;
		one = 1 << FRAC;
		r.h = '0;
		r.ins = 1'b0;
		if (!grid_pos(wx, wz, base, n, fx, fz)) return r;
		// lower or upper triangle of the cell
		if (fx + fz <= one)
			sum = corner(base) * (one - fx - fz) + corner(base + 1) * fx
				+ corner(base + n) * fz;
		else
			sum = corner(base + 1) * (one - fz) + corner(base + n + 1) * (fx + fz - one)
				+ corner(base + n) * (one - fx);
		r.h = clamp16((sum + (one >>> 1)) >>> FRAC);
		r.ins = 1'b1;
		return r;
	endfunction

	// offer one beat and wait for it to be taken
	task automatic send_beat(logic k, logic [15:0] idx, logic [15:0] smp,
		logic signed [23:0] wx, logic signed [23:0] wz, bit typed = 0,
		height_res_t want = '{0, 0});
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		grid_index <= idx;
		sample <= smp;
		world_x <= wx;
		world_z <= wz;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (k == KIND_LOAD) begin
			heights[idx] = load_height(smp);
			loaded[idx] = 1'b1;
		end else begin
			pending_heights.push_back(typed ? want : query_height(wx, wz));
		end
	endtask

	// query, loading any corner that was never written first
	task automatic send_query(logic signed [23:0] wx, logic signed [23:0] wz);
		longint base, n, fx, fz;
		longint a [4];
		if (grid_pos(wx, wz, base, n, fx, fz)) begin
			a = '{base, base + 1, base + n, base + n + 1};
			foreach (a[i])
				if (!loaded[a[i][15:0]])
					send_beat(KIND_LOAD, a[i][15:0], 16'($urandom), '0, '0);
		end
		send_beat(KIND_QUERY, 16'($urandom), 16'($urandom), wx, wz);
	endtask

	// let the block drain, then write the registers
	task automatic apply_setting(setting_t s);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_heights.size() != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ORIGIN_X;
		cfg_data <= s.ox;
		@(posedge clk);
		cfg_index <= CFG_ORIGIN_Z;
		cfg_data <= s.oz;
		@(posedge clk);
		cfg_index <= CFG_TERRAIN_SIZE;
		cfg_data <= s.size;
		@(posedge clk);
		cfg_index <= CFG_GRID_POINTS;
		cfg_data <= s.gp;
		@(posedge clk);
		cfg_index <= CFG_MAX_HEIGHT;
		cfg_data <= s.mh;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_ox = s.ox;
		m_oz = s.oz;
		m_size = s.size[22:0];
		m_gp = s.gp[8:0];
		m_mh = s.mh[13:0];
	endtask

	// result side: stall draws, long hold-off and checking
	always @(posedge clk) begin
		height_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_heights.size() == 0) begin
				errors++;
				$display("%0t unexpected result beat: height %0d inside %0d",
					$realtime, height, inside_res);
			end else begin
				e = pending_heights.pop_front();
				if (height !== e.h) begin
					errors++;
					$display("%0t height mismatch: expected %0d, got %0d",
						$realtime, e.h, height);
				end
				if (inside_res !== e.ins) begin
					errors++;
					$display("%0t inside_res mismatch: expected %0d, got %0d",
						$realtime, e.ins, inside_res);
				end
			end
		end
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_wait = calm ? 0 : $urandom_range(0, 6);
			out_stall <= out_wait != 0;
		end else if (out_wait > 0) begin
			out_wait--;
			out_stall <= out_wait != 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	stim_row_t directed [] = '{
		'{KIND_LOAD, 16'd0, 16'd0, 0, 0, 0, 0, 0},
		'{KIND_LOAD, 16'd1, 16'hFFFF, 0, 0, 0, 0, 0},
		'{KIND_LOAD, 16'd256, 16'h8000, 0, 0, 0, 0, 0},
		'{KIND_LOAD, 16'd257, 16'hFFFF, 0, 0, 0, 0, 0},
		'{KIND_LOAD, 16'hFFFF, 16'h5A5A, 0, 0, 0, 0, 0},
		// origin corner: exactly the first sample, zero minus the offset
		'{KIND_QUERY, 16'd0, 16'd0, 0, 0, 1, -16'sd256, 1},
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd128, 24'sd100, 0, 0, 0},
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd3, 24'sd250, 0, 0, 0},
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd255, 24'sd255, 0, 0, 0},
		// left of or before the origin is outside
		'{KIND_QUERY, 16'd0, 16'd0, -24'sd1, 24'sd0, 1, 0, 0},
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd0, -24'sd1, 1, 0, 0},
		'{KIND_QUERY, 16'd0, 16'd0, -24'sd8388608, -24'sd8388608, 1, 0, 0},
		// past the far edge of the terrain
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd8388607, 24'sd8388607, 1, 0, 0},
		'{KIND_QUERY, 16'd0, 16'd0, 24'sd204800, 24'sd0, 1, 0, 0}
	};

	setting_t settings [] = '{
		'{0, 0, 1024, 5, 16383},
		'{-24'sd8388608, -24'sd8388608, 24'd8388607, 2, 0},
		'{24'sd8388607, -24'sd1000, 256, 17, 300},
		'{24'sd1234, -24'sd5678, 0, 3, 512},            // zero size acts as one
		'{0, 0, 5000, 0, 1000},                         // too few points acts as two
		'{-24'sd300, 24'sd700, 65536, 511, 16383},      // too many points clamps
		'{24'sd100, 24'sd100, 777, 256, 256},
		'{0, 0, 3, 1, 20},
		'{-24'sd5000, 24'sd5000, 200000, 64, 8000},
		'{24'sd77, -24'sd77, 24'h800000 | 24'd40000, 9, 12345}
	};

	// stimulus
	initial begin
		height_res_t want;
		longint span, t;
		logic signed [23:0] wx, wz;
		int per_phase;
		int goal;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			want.h = directed[i].h;
			want.ins = directed[i].ins;
			send_beat(directed[i].k, directed[i].idx, directed[i].smp,
				directed[i].wx, directed[i].wz, directed[i].typed, want);
		end
		per_phase = (ITEMS - items_sent) / settings.size();
		foreach (settings[p]) begin
			apply_setting(settings[p]);
			calm = (p == 2);
			if (p == 6)
				long_hold = 400;
			span = m_size == 0 ? 1 : m_size;
			goal = items_sent + per_phase;
			while (items_sent < goal) begin
				case ($urandom_range(0, 9))
					0, 1: send_beat(KIND_LOAD, 16'($urandom), 16'($urandom), 24'($urandom),
						24'($urandom));
					2: send_query(24'($urandom), 24'($urandom));
					default: begin
						t = $urandom_range(0, 31) == 0 ? span : longint'($urandom) % span;
						wx = 24'(longint'(m_ox) + t);
						t = $urandom_range(0, 31) == 0 ? span : longint'($urandom) % span;
						wz = 24'(longint'(m_oz) + t);
						send_query(wx, wz);
					end
				endcase
			end
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_heights.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_heights.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
